FILE: design/dfir_pkg.sv
// ----------------------------------------------------------------------------
// dfir_pkg
// Shared types, codes and defaults for the chip fault isolation and recovery
// block.
// ----------------------------------------------------------------------------
package dfir_pkg;

   localparam int NUM_CHIPS_DEFAULT = 9;

   localparam int LIMIT_W    = 10;
   localparam int INTERVAL_W = 20;
   localparam int DEVICES_W  = 4;
   localparam int SLOT_W     = 4;
   localparam int SETUP_W    = 8;
   localparam int TOTAL_W    = 32;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 20;
   localparam int INC_W      = 9;

   localparam logic [CSR_IDX_W-1:0] CSR_FAILURE_LIMIT  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_RETRY_INTERVAL = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_DEVICES_IN_USE = 2'd2;

   localparam logic [LIMIT_W-1:0]    FAILURE_LIMIT_RST  = 10'd3;
   localparam logic [INTERVAL_W-1:0] RETRY_INTERVAL_RST = 20'd40;
   localparam logic [DEVICES_W-1:0]  DEVICES_RST        = 4'd9;

   localparam logic [LIMIT_W-1:0] CONS_MAX = '1;
   localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;

   typedef enum logic [2:0] {
      ST_WAITING     = 3'd0,
      ST_DEFERRED    = 3'd1,
      ST_REC_FAIL    = 3'd2,
      ST_READ_OK     = 3'd3,
      ST_REALIGNED   = 3'd4,
      ST_ISO_LIMIT   = 3'd5,
      ST_ISO_REALIGN = 3'd6,
      ST_IGNORED     = 3'd7
   } status_type;

   // fields listed from the highest bit down, so chip_slot lands in the low bits
   typedef struct packed {
      logic               realign_ok;
      logic               read_ok;
      logic [SETUP_W-1:0] setup_fail_count;
      logic               setup_ok;
      logic               init_ok;
      logic               frame_begin;
      logic [SLOT_W-1:0]  chip_slot;
   } req_type;

   typedef struct packed {
      logic [INTERVAL_W-1:0] countdown;
      logic [TOTAL_W-1:0]    total_count;
      logic [LIMIT_W-1:0]    consecutive_count;
      logic                  chip_online;
      logic                  samples_usable;
      logic                  recovered;
      status_type            status;
   } rsp_type;

   typedef struct packed {
      logic                  online;
      logic [LIMIT_W-1:0]    consecutive;
      logic [TOTAL_W-1:0]    total;
      logic [INTERVAL_W-1:0] countdown;
   } chip_state_type;

   typedef struct packed {
      logic [LIMIT_W-1:0]    failure_limit;
      logic [INTERVAL_W-1:0] retry_interval;
   } cfg_type;

   localparam int REQ_W      = $bits(req_type);
   localparam int RSP_W      = $bits(rsp_type);
   localparam int REQ_DATA_W = ((REQ_W + 7) / 8) * 8;
   localparam int RSP_DATA_W = ((RSP_W + 7) / 8) * 8;

endpackage

FILE: design/device_fault_isolation_recovery_core.sv
// ----------------------------------------------------------------------------
// device_fault_isolation_recovery_core
// Per-frame health policy for a group of sensor chips, one chip slot per word.
// ----------------------------------------------------------------------------
// path: an accepted req word passes the input register, then the policy logic
// into the result register; one word per cycle unless rsp_tready stalls it;
// the chip table read-modify-write closes in the single policy stage, so
// back-to-back slots of the same chip need no stall
// reset: synchronous, clears every chip to offline with zero counts and
// countdown, clears the frame recovery mark and loads the register defaults
module device_fault_isolation_recovery_core #(
   parameter int NUM_CHIPS = dfir_pkg::NUM_CHIPS_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   // chip_slot[3:0], frame_begin, init_ok, setup_ok, setup_fail_count[7:0],
   // read_ok, realign_ok, zero fill
   input  logic [dfir_pkg::REQ_DATA_W-1:0]     req_tdata,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // status[2:0], recovered, samples_usable, chip_online, consecutive_count[9:0],
   // total_count[31:0], countdown[19:0], zero fill
   output logic [dfir_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   input  logic                                csr_we,
   input  logic [dfir_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [dfir_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   localparam int IDX_W = (NUM_CHIPS > 1) ? $clog2(NUM_CHIPS) : 1;
   localparam logic [dfir_pkg::SLOT_W:0] NUM_CHIPS_W = (dfir_pkg::SLOT_W + 1)'(NUM_CHIPS);

   logic [dfir_pkg::LIMIT_W-1:0]    failure_limit_ff;
   logic [dfir_pkg::INTERVAL_W-1:0] retry_interval_ff;
   logic [dfir_pkg::DEVICES_W-1:0]  devices_ff;

   logic                     in_valid_ff;
   dfir_pkg::req_type        in_ff;
   logic                     tried_ff;
   logic                     rsp_valid_ff;
   dfir_pkg::rsp_type        rsp_ff;

   logic                     advance;
   logic                     in_range;
   logic [IDX_W-1:0]         idx;
   dfir_pkg::cfg_type        cfg;
   dfir_pkg::chip_state_type cur;
   dfir_pkg::chip_state_type nxt;
   logic                     pol_wr;
   logic                     tried_in;
   logic                     attempt;
   dfir_pkg::rsp_type        rsp_in;

   assign advance    = in_valid_ff & (~rsp_valid_ff | rsp_tready);
   assign req_tready = ~in_valid_ff | advance;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(dfir_pkg::RSP_DATA_W - dfir_pkg::RSP_W){1'b0}}, rsp_ff};

   assign in_range = ({1'b0, in_ff.chip_slot} < {1'b0, devices_ff}) &&
                     ({1'b0, in_ff.chip_slot} < NUM_CHIPS_W);
   assign idx      = in_ff.chip_slot[IDX_W-1:0];
   assign cfg.failure_limit  = failure_limit_ff;
   assign cfg.retry_interval = retry_interval_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         failure_limit_ff  <= dfir_pkg::FAILURE_LIMIT_RST;
         retry_interval_ff <= dfir_pkg::RETRY_INTERVAL_RST;
         devices_ff        <= dfir_pkg::DEVICES_RST;
      end else if (csr_we) begin
         case (csr_index)
            dfir_pkg::CSR_FAILURE_LIMIT: begin
               failure_limit_ff <= csr_wdata[dfir_pkg::LIMIT_W-1:0];
            end
            dfir_pkg::CSR_RETRY_INTERVAL: begin
               retry_interval_ff <= csr_wdata[dfir_pkg::INTERVAL_W-1:0];
            end
            dfir_pkg::CSR_DEVICES_IN_USE: begin
               devices_ff <= csr_wdata[dfir_pkg::DEVICES_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         tried_ff     <= 1'b0;
      end else begin
         if (req_tready) begin
            in_valid_ff <= req_tvalid;
         end
         if (advance) begin
            rsp_valid_ff <= 1'b1;
            tried_ff     <= tried_in;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready & req_tvalid) begin
         in_ff <= dfir_pkg::req_type'(req_tdata[dfir_pkg::REQ_W-1:0]);
      end
      if (advance) begin
         rsp_ff <= rsp_in;
      end
   end

   dfir_chip_table #(
      .NUM_CHIPS (NUM_CHIPS),
      .IDX_W     (IDX_W)
   ) u_table (
      .clock   (clock),
      .reset   (reset),
      .rd_idx  (idx),
      .rd_data (cur),
      .wr_en   (advance & pol_wr),
      .wr_idx  (idx),
      .wr_data (nxt)
   );

   dfir_policy u_policy (
      .req       (in_ff),
      .cur       (cur),
      .cfg       (cfg),
      .in_range  (in_range),
      .tried     (tried_ff),
      .nxt       (nxt),
      .wr_en     (pol_wr),
      .tried_nxt (tried_in),
      .attempt   (attempt),
      .rsp       (rsp_in)
   );

`ifndef NO_ASSERTIONS
   // online after the slot exactly when the read path left the chip served
   a_online_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_ff.chip_online ==
         (rsp_ff.status == dfir_pkg::ST_READ_OK || rsp_ff.status == dfir_pkg::ST_REALIGNED)))
      else $error("chip_online disagrees with status");

   a_valid_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_ff.samples_usable == (rsp_ff.status == dfir_pkg::ST_READ_OK)))
      else $error("samples_usable disagrees with status");

   a_recovered_read: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.recovered) |->
         (rsp_ff.status != dfir_pkg::ST_WAITING && rsp_ff.status != dfir_pkg::ST_DEFERRED &&
          rsp_ff.status != dfir_pkg::ST_REC_FAIL && rsp_ff.status != dfir_pkg::ST_IGNORED))
      else $error("recovered slot skipped the read");

   a_tried_set: assert property (@(posedge clock) disable iff (reset)
      (advance && attempt) |=> tried_ff)
      else $error("recovery mark not set after an attempt");
`endif

endmodule

FILE: design/dfir_chip_table.sv
// ----------------------------------------------------------------------------
// dfir_chip_table
// Per-chip health registers: online mark, failure counts and retry countdown,
// one read port and one write port.
// ----------------------------------------------------------------------------
module dfir_chip_table #(
   parameter int NUM_CHIPS = dfir_pkg::NUM_CHIPS_DEFAULT,
   parameter int IDX_W     = 4
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic [IDX_W-1:0]         rd_idx,
   output dfir_pkg::chip_state_type rd_data,
   input  logic                     wr_en,
   input  logic [IDX_W-1:0]         wr_idx,
   input  dfir_pkg::chip_state_type wr_data
);

   dfir_pkg::chip_state_type chip_ff [NUM_CHIPS];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_CHIPS; i++) begin
            chip_ff[i] <= '0;
         end
      end else if (wr_en) begin
         chip_ff[wr_idx] <= wr_data;
      end
   end

   // indexes past the last chip never reach here with a write; reads there are masked
   always_comb begin
      rd_data = '0;
      for (int i = 0; i < NUM_CHIPS; i++) begin
         if (rd_idx == IDX_W'(i)) begin
            rd_data = chip_ff[i];
         end
      end
   end

endmodule

FILE: design/dfir_policy.sv
// ----------------------------------------------------------------------------
// dfir_policy
// Health policy for one chip slot: countdown, single recovery per frame,
// read outcome, isolation, and the saturating failure counters.
// ----------------------------------------------------------------------------
module dfir_policy (
   input  dfir_pkg::req_type        req,
   input  dfir_pkg::chip_state_type cur,
   input  dfir_pkg::cfg_type        cfg,
   input  logic                     in_range,
   input  logic                     tried,
   output dfir_pkg::chip_state_type nxt,
   output logic                     wr_en,
   output logic                     tried_nxt,
   output logic                     attempt,
   output dfir_pkg::rsp_type        rsp
);

   logic                               tried_eff;
   logic                               go_read;
   logic                               recovered;
   logic                               valid;
   logic                               rec_ok;
   logic [dfir_pkg::LIMIT_W-1:0]       cons_base;
   logic [dfir_pkg::LIMIT_W-1:0]       cons_inc;
   logic [dfir_pkg::INC_W-1:0]         inc;
   logic [dfir_pkg::TOTAL_W:0]         total_sum;
   dfir_pkg::status_type               status;

   always_comb begin
      tried_eff = req.frame_begin ? 1'b0 : tried;
      nxt       = cur;
      go_read   = 1'b1;
      recovered = 1'b0;
      valid     = 1'b0;
      attempt   = 1'b0;
      rec_ok    = 1'b0;
      inc       = '0;
      cons_inc  = '0;
      status    = dfir_pkg::ST_WAITING;

      if (!cur.online) begin
         go_read = 1'b0;
         if (cur.countdown != '0) begin
            nxt.countdown = cur.countdown - 1'b1;
         end else if (tried_eff) begin
            status = dfir_pkg::ST_DEFERRED;
         end else begin
            attempt = 1'b1;
            if (!req.init_ok) begin
               inc = dfir_pkg::INC_W'(1);
            end else begin
               inc    = dfir_pkg::INC_W'(req.setup_fail_count);
               rec_ok = req.setup_ok;
            end
            if (!rec_ok) begin
               nxt.countdown = cfg.retry_interval;
               status        = dfir_pkg::ST_REC_FAIL;
            end else begin
               nxt.online = 1'b1;
               recovered  = 1'b1;
               go_read    = 1'b1;
            end
         end
      end

      cons_base = recovered ? '0 : cur.consecutive;

      if (go_read) begin
         if (req.read_ok) begin
            nxt.consecutive = '0;
            valid           = 1'b1;
            status          = dfir_pkg::ST_READ_OK;
         end else begin
            cons_inc = (cons_base == dfir_pkg::CONS_MAX) ? cons_base : cons_base + 1'b1;
            nxt.consecutive = cons_inc;
            inc = inc + 1'b1;
            if (cons_inc >= cfg.failure_limit) begin
               nxt.online    = 1'b0;
               nxt.countdown = cfg.retry_interval;
               status        = dfir_pkg::ST_ISO_LIMIT;
            end else if (!req.realign_ok) begin
               inc           = inc + 1'b1;
               nxt.online    = 1'b0;
               nxt.countdown = cfg.retry_interval;
               status        = dfir_pkg::ST_ISO_REALIGN;
            end else begin
               status = dfir_pkg::ST_REALIGNED;
            end
         end
      end

      // one add for all failures of the slot; saturating once matches stepwise
      total_sum = {1'b0, cur.total} + (dfir_pkg::TOTAL_W + 1)'(inc);
      nxt.total = total_sum[dfir_pkg::TOTAL_W] ? dfir_pkg::TOTAL_MAX
                                               : total_sum[dfir_pkg::TOTAL_W-1:0];

      if (!in_range) begin
         attempt = 1'b0;
         rsp     = '0;
         rsp.status = dfir_pkg::ST_IGNORED;
      end else begin
         rsp.status            = status;
         rsp.recovered         = recovered;
         rsp.samples_usable    = valid;
         rsp.chip_online       = nxt.online;
         rsp.consecutive_count = nxt.consecutive;
         rsp.total_count       = nxt.total;
         rsp.countdown         = nxt.countdown;
      end

      wr_en     = in_range;
      tried_nxt = attempt | tried_eff;
   end

endmodule

FILE: tb/fault_policy_checker.sv
// ----------------------------------------------------------------------------
// fault_policy_checker
// Watches the req, rsp and csr ports of the chip fault isolation core, keeps
// its own chip table and register copy, predicts each rsp word and compares
// it field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module fault_policy_checker
   import dfir_pkg::*;
#(
   parameter int NUM_CHIPS = NUM_CHIPS_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic [REQ_DATA_W-1:0] req_tdata,
   input  logic                  req_tvalid,
   input  logic                  req_tready,
   input  logic [RSP_DATA_W-1:0] rsp_tdata,
   input  logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   output int                    mismatches,
   output int                    pending
);

   logic [LIMIT_W-1:0]    limit_copy;
   logic [INTERVAL_W-1:0] interval_copy;
   logic [DEVICES_W-1:0]  served_copy;

   logic                  chip_up    [NUM_CHIPS];
   logic [LIMIT_W-1:0]    fail_run   [NUM_CHIPS];
   logic [TOTAL_W-1:0]    fail_total [NUM_CHIPS];
   logic [INTERVAL_W-1:0] retry_wait [NUM_CHIPS];
   logic                  recovery_used;

   rsp_type expected_rsp_q [$];

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      mismatches++;
      if (mismatches <= 30)
         $display("[%0t] rsp mismatch on %s: got %0d, expected %0d", $time, what, got, want);
   endtask

   function automatic logic [TOTAL_W-1:0] add_saturated(input logic [TOTAL_W-1:0] a,
                                                        input logic [TOTAL_W-1:0] b);
      logic [TOTAL_W:0] sum;
      sum = {1'b0, a} + {1'b0, b};
      return sum[TOTAL_W] ? TOTAL_MAX : sum[TOTAL_W-1:0];
   endfunction

   // one chip slot through the health policy, updating the local chip table
   function automatic rsp_type predict_slot(input req_type w);
      rsp_type r;
      logic    go_read;
      logic    brought_up;
      int      c;
      r        = '0;
      r.status = ST_WAITING;
      go_read  = 1'b1;
      if (w.frame_begin)
         recovery_used = 1'b0;
      if (w.chip_slot >= served_copy || w.chip_slot >= NUM_CHIPS) begin
         r.status = ST_IGNORED;
         return r;
      end
      c = w.chip_slot;
      if (!chip_up[c]) begin
         go_read = 1'b0;
         if (retry_wait[c] != '0) begin
            retry_wait[c] = retry_wait[c] - 1'b1;
         end else if (recovery_used) begin
            r.status = ST_DEFERRED;
         end else begin
            recovery_used = 1'b1;
            if (!w.init_ok) begin
               fail_total[c] = add_saturated(fail_total[c], 1);
               brought_up    = 1'b0;
            end else begin
               // setup failures count even when the setup itself succeeded
               fail_total[c] = add_saturated(fail_total[c], TOTAL_W'(w.setup_fail_count));
               brought_up    = w.setup_ok;
            end
            if (!brought_up) begin
               retry_wait[c] = interval_copy;
               r.status      = ST_REC_FAIL;
            end else begin
               chip_up[c]  = 1'b1;
               fail_run[c] = '0;
               r.recovered = 1'b1;
               go_read     = 1'b1;
            end
         end
      end
      if (go_read) begin
         if (w.read_ok) begin
            fail_run[c]      = '0;
            r.samples_usable = 1'b1;
            r.status         = ST_READ_OK;
         end else begin
            if (fail_run[c] != CONS_MAX)
               fail_run[c] = fail_run[c] + 1'b1;
            fail_total[c] = add_saturated(fail_total[c], 1);
            if (fail_run[c] >= limit_copy) begin
               chip_up[c]    = 1'b0;
               retry_wait[c] = interval_copy;
               r.status      = ST_ISO_LIMIT;
            end else if (!w.realign_ok) begin
               // failed realign costs one more transport failure
               fail_total[c] = add_saturated(fail_total[c], 1);
               chip_up[c]    = 1'b0;
               retry_wait[c] = interval_copy;
               r.status      = ST_ISO_REALIGN;
            end else begin
               r.status = ST_REALIGNED;
            end
         end
      end
      r.chip_online       = chip_up[c];
      r.consecutive_count = fail_run[c];
      r.total_count       = fail_total[c];
      r.countdown         = retry_wait[c];
      return r;
   endfunction

   always @(posedge clock) begin
      rsp_type got;
      rsp_type want;
      if (reset) begin
         limit_copy    = FAILURE_LIMIT_RST;
         interval_copy = RETRY_INTERVAL_RST;
         served_copy   = DEVICES_RST;
         for (int i = 0; i < NUM_CHIPS; i++) begin
            chip_up[i]    = 1'b0;
            fail_run[i]   = '0;
            fail_total[i] = '0;
            retry_wait[i] = '0;
         end
         recovery_used = 1'b0;
         expected_rsp_q.delete();
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_FAILURE_LIMIT:  limit_copy    = csr_wdata[LIMIT_W-1:0];
               CSR_RETRY_INTERVAL: interval_copy = csr_wdata[INTERVAL_W-1:0];
               CSR_DEVICES_IN_USE: served_copy   = csr_wdata[DEVICES_W-1:0];
               default: ;
            endcase
         end
         if (req_tvalid && req_tready)
            expected_rsp_q.push_back(predict_slot(req_type'(req_tdata[REQ_W-1:0])));
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_type'(rsp_tdata[RSP_W-1:0]);
            if (expected_rsp_q.size() == 0) begin
               report_mismatch("unexpected word, status", 32'(got.status), 32'(ST_IGNORED));
            end else begin
               want = expected_rsp_q.pop_front();
               if (got.status !== want.status)
                  report_mismatch("status", 32'(got.status), 32'(want.status));
               if (got.recovered !== want.recovered)
                  report_mismatch("recovered", 32'(got.recovered), 32'(want.recovered));
               if (got.samples_usable !== want.samples_usable)
                  report_mismatch("samples_usable", 32'(got.samples_usable),
                                  32'(want.samples_usable));
               if (got.chip_online !== want.chip_online)
                  report_mismatch("chip_online", 32'(got.chip_online), 32'(want.chip_online));
               if (got.consecutive_count !== want.consecutive_count)
                  report_mismatch("consecutive_count", 32'(got.consecutive_count),
                                  32'(want.consecutive_count));
               if (got.total_count !== want.total_count)
                  report_mismatch("total_count", got.total_count, want.total_count);
               if (got.countdown !== want.countdown)
                  report_mismatch("countdown", 32'(got.countdown), 32'(want.countdown));
            end
         end
      end
      pending <= expected_rsp_q.size();
   end

endmodule

FILE: tb/device_fault_isolation_recovery_core_test.sv
// ----------------------------------------------------------------------------
// device_fault_isolation_recovery_core_test
// Drives chip slot words and register settings into the fault isolation core,
// first a directed walk through recovery, realign and isolation, then random
// frames under several settings with random gaps and rsp stalls.
// ----------------------------------------------------------------------------
module device_fault_isolation_recovery_core_test;
   import dfir_pkg::*;

   localparam int NUM_CHIPS = NUM_CHIPS_DEFAULT;

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic                  csr_we     = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index  = CSR_FAILURE_LIMIT;
   logic [CSR_DATA_W-1:0] csr_wdata  = '0;

   int   mismatches;
   int   pending;
   logic quiet        = 1'b0;
   int   gap_pct      = 0;
   int   slots_served = DEVICES_RST;

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   device_fault_isolation_recovery_core #(.NUM_CHIPS(NUM_CHIPS)) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   fault_policy_checker #(.NUM_CHIPS(NUM_CHIPS)) u_checker (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .mismatches (mismatches),
      .pending    (pending)
   );

   function automatic req_type slot_word(input int slot, input int fb, input int init,
                                         input int setup, input int fails,
                                         input int rd, input int realign);
      req_type w;
      w.chip_slot        = SLOT_W'(slot);
      w.frame_begin      = 1'(fb);
      w.init_ok          = 1'(init);
      w.setup_ok         = 1'(setup);
      w.setup_fail_count = SETUP_W'(fails);
      w.read_ok          = 1'(rd);
      w.realign_ok       = 1'(realign);
      return w;
   endfunction

   function automatic req_type random_word(input int slot, input logic fb, input int fail_pct);
      req_type w;
      w.chip_slot        = SLOT_W'(slot);
      w.frame_begin      = fb;
      w.init_ok          = ($urandom_range(0, 9) != 0);
      w.setup_ok         = ($urandom_range(0, 7) != 0);
      w.setup_fail_count = ($urandom_range(0, 2) == 0) ? SETUP_W'($urandom_range(0, 255)) : '0;
      w.read_ok          = ($urandom_range(0, 99) >= fail_pct);
      w.realign_ok       = ($urandom_range(0, 4) != 0);
      return w;
   endfunction

   // called just after a rising edge; returns at the edge that took the word
   task automatic send_word(input req_type w);
      if (!quiet && gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 11)) @(posedge clock);
      end
      req_tdata  <= REQ_DATA_W'(w);
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
   endtask

   // drop valid and wait until every rsp word has been taken
   task automatic settle();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
   endtask

   task automatic apply_settings(input int limit, input int interval, input int devices);
      csr_we    <= 1'b1;
      csr_index <= CSR_FAILURE_LIMIT;
      csr_wdata <= CSR_DATA_W'(limit);
      @(posedge clock);
      csr_index <= CSR_RETRY_INTERVAL;
      csr_wdata <= CSR_DATA_W'(interval);
      @(posedge clock);
      csr_index <= CSR_DEVICES_IN_USE;
      csr_wdata <= CSR_DATA_W'(devices);
      @(posedge clock);
      csr_we       <= 1'b0;
      slots_served = devices;
   endtask

   // mostly whole frames in slot order, the rest stray words
   task automatic run_traffic(input int words, input int fail_pct);
      int      sent;
      int      last_slot;
      int      s;
      req_type w;
      sent = 0;
      while (sent < words) begin
         if ($urandom_range(0, 99) < 85) begin
            last_slot = ($urandom_range(0, 9) == 0) ? NUM_CHIPS - 1 : slots_served - 1;
            for (s = 0; s <= last_slot; s++) begin
               send_word(random_word(s, s == 0, fail_pct));
               sent++;
            end
         end else begin
            w = random_word($urandom_range(0, NUM_CHIPS - 1), 1'($urandom_range(0, 1)), 50);
            send_word(w);
            sent++;
         end
      end
   endtask

   initial begin
      #2000000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   initial begin : rsp_stall
      forever begin
         @(posedge clock);
         if (!quiet && $urandom_range(0, 3) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         repeat ($urandom_range(0, 40)) @(posedge clock);
      end
   end

   initial begin : stimulus
      int ph;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // register defaults: limit 3, interval 40, all chips served
      send_word(slot_word(0, 1, 0, 1, 255, 1, 1));   // failed init, setup ignored
      send_word(slot_word(1, 0, 1, 1, 0, 1, 1));     // deferred, recovery used this frame
      send_word(slot_word(1, 1, 1, 1, 255, 1, 1));   // recovered with setup failures
      send_word(slot_word(1, 1, 0, 0, 255, 0, 1));   // online, unused outcomes ignored
      send_word(slot_word(1, 0, 1, 1, 0, 0, 1));
      send_word(slot_word(1, 0, 1, 1, 0, 0, 1));     // third failure hits the limit
      send_word(slot_word(0, 1, 1, 1, 0, 1, 1));     // still counting down
      send_word(slot_word(8, 1, 1, 0, 200, 1, 1));   // failed setup on the top chip

      settle();
      apply_settings(1, 1, 3);
      send_word(slot_word(8, 1, 1, 1, 255, 1, 1));   // ignored, still clears the frame mark
      send_word(slot_word(2, 0, 1, 0, 7, 1, 1));
      send_word(slot_word(5, 1, 0, 0, 0, 0, 0));     // ignored
      send_word(slot_word(2, 0, 1, 1, 0, 1, 1));
      send_word(slot_word(2, 0, 1, 1, 0, 0, 1));     // recovered, then a limit of one
      send_word(slot_word(2, 1, 1, 1, 0, 1, 1));
      send_word(slot_word(2, 1, 1, 1, 0, 1, 1));

      settle();
      apply_settings(1000, 1, 1);
      send_word(slot_word(0, 1, 1, 1, 0, 1, 1));
      send_word(slot_word(1, 1, 1, 1, 0, 1, 1));     // ignored with one chip served
      send_word(slot_word(0, 1, 1, 1, 3, 0, 0));     // chip 0 still counting down, outcomes unused
      send_word(slot_word(0, 1, 1, 1, 0, 1, 1));
      send_word(slot_word(0, 1, 1, 1, 0, 0, 1));
      send_word(slot_word(0, 0, 0, 0, 0, 0, 1));     // still counting down

      for (ph = 0; ph < 9; ph++) begin
         settle();
         case (ph)
            0:       apply_settings(1, 1, 1);
            8:       apply_settings($urandom_range(1, 1000), $urandom_range(1, 1000000),
                                    $urandom_range(1, NUM_CHIPS));
            default: apply_settings($urandom_range(1, 6), $urandom_range(1, 5),
                                    $urandom_range(1, NUM_CHIPS));
         endcase
         case ($urandom_range(0, 2))
            0:       gap_pct = 0;
            1:       gap_pct = 15;
            default: gap_pct = 50;
         endcase
         run_traffic(115, $urandom_range(5, 40));
      end

      // last stretch at the top of the random setting ranges with no idling
      settle();
      apply_settings(1000, 1000000, NUM_CHIPS);
      quiet   = 1'b1;
      gap_pct = 0;
      run_traffic(115, 25);

      settle();
      repeat (4) @(posedge clock);
      if (mismatches == 0 && pending == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
